// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/ebmf_pkg.sv =====
// constants, register indexes and the term scaling function
// no dependencies
package ebmf_pkg;
   typedef enum logic [2:0] {
      REG_ANTIALIAS = 3'd0,
      REG_X_SCALE   = 3'd1,
      REG_Y_SCALE   = 3'd2,
      REG_FX_SCALE  = 3'd3,
      REG_FY_SCALE  = 3'd4
   } reg_index_type;

   localparam logic [31:0] SCALE_ONE  = 32'h0100_0000;
   localparam logic [22:0] OUTER_LIM  = 23'h02_0000;
   localparam logic [22:0] FADE_LIM   = 23'h40_0000;
   localparam logic [33:0] AA_ONE     = 34'h4_0000;
   localparam logic [45:0] NORM_ONE   = 46'h1_0000_0000;
   localparam logic [15:0] FULL_OUT   = 16'h8000;
   localparam int          QBITS      = 15;

   // floor((hi_prod * 2^16 + lo_prod) / 2^26), saturated at lim
   function automatic logic [22:0] scale_term(input logic [49:0] hi_prod,
                                              input logic [49:0] lo_prod,
                                              input logic [22:0] lim);
      logic [66:0] sum;
      logic [40:0] raw;
      sum = {1'b0, hi_prod, 16'b0} + {17'b0, lo_prod};
      raw = sum[66:26];
      if (raw > {18'b0, lim}) begin
         return lim;
      end
      return raw[22:0];
   endfunction
endpackage

// ===== hdl/ellipse_brush_mask_fade_top.sv =====
// elliptical brush mask with fade ellipse, full pipeline with restoring divider
// depends on ebmf_pkg
// throughput one word per cycle while the result word is not stalled
// the pipeline moves as a whole and holds while the result word is stalled
// the divider checks for overflow in one stage, then takes one quotient bit per stage over 15
// synchronous active-high reset clears valid bits and antialias and loads default scales
module ellipse_brush_mask_fade_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_pixel_x,
   input  logic [15:0]        req_row_y,
   input  logic [15:0]        req_center_x,
   input  logic [15:0]        req_center_y,
   input  logic signed [15:0] req_cos_angle,
   input  logic signed [15:0] req_sin_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_fade_value,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   localparam int QB = ebmf_pkg::QBITS;

   logic        aa_ff;
   logic [31:0] xs_ff, ys_ff, fxs_ff, fys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         aa_ff  <= 1'b0;
         xs_ff  <= ebmf_pkg::SCALE_ONE;
         ys_ff  <= ebmf_pkg::SCALE_ONE;
         fxs_ff <= ebmf_pkg::SCALE_ONE;
         fys_ff <= ebmf_pkg::SCALE_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            ebmf_pkg::REG_ANTIALIAS: aa_ff  <= csr_wdata[0];
            ebmf_pkg::REG_X_SCALE:   xs_ff  <= csr_wdata;
            ebmf_pkg::REG_Y_SCALE:   ys_ff  <= csr_wdata;
            ebmf_pkg::REG_FX_SCALE:  fxs_ff <= csr_wdata;
            ebmf_pkg::REG_FY_SCALE:  fys_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic vd_ff [0:QB];

   logic signed [16:0] dx_ff, dy_ff;
   logic signed [15:0] c_ff, s_ff;
   logic signed [32:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic [33:0]        mx_ff, my_ff, ax_ff, ay_ff;
   logic [49:0]        mxh_ff, mxl_ff, myh_ff, myl_ff;
   logic [49:0]        axh_ff, axl_ff, ayh_ff, ayl_ff;
   logic [17:0]        tx_ff, ty_ff;
   logic [22:0]        fx_ff, fy_ff;
   logic [35:0]        sqx_ff, sqy_ff;
   logic [45:0]        sfx_ff, sfy_ff;
   logic [35:0]        n_ff;
   logic [45:0]        f_ff;
   logic               fix8_ff, fix9_ff;
   logic [15:0]        fv8_ff, fv9_ff;
   logic [15:0]        nh_ff;
   logic [45:0]        fm_ff, den8_ff, den9_ff;
   logic [61:0]        num_ff;

   logic [61:0] rem_ff [0:QB];
   logic [45:0] den_ff [0:QB];
   logic [15:0] q_ff   [0:QB];
   logic        dv_ff  [0:QB];

   logic signed [33:0] xr_in, yr_in;
   logic [33:0]        mx_in, my_in;
   logic [22:0]        tx_in, ty_in, fx_in, fy_in;
   logic [35:0]        n_in;
   logic [45:0]        f_in;
   logic [62:0]        trial_in [1:QB];

   always_comb begin
      xr_in = 34'(pxc_ff) - 34'(pys_ff);
      yr_in = 34'(pxs_ff) + 34'(pyc_ff);
      mx_in = xr_in[33] ? 34'(-xr_in) : 34'(xr_in);
      my_in = yr_in[33] ? 34'(-yr_in) : 34'(yr_in);
      tx_in = ebmf_pkg::scale_term(mxh_ff, mxl_ff, ebmf_pkg::OUTER_LIM);
      ty_in = ebmf_pkg::scale_term(myh_ff, myl_ff, ebmf_pkg::OUTER_LIM);
      fx_in = ebmf_pkg::scale_term(axh_ff, axl_ff, ebmf_pkg::FADE_LIM);
      fy_in = ebmf_pkg::scale_term(ayh_ff, ayl_ff, ebmf_pkg::FADE_LIM);
      n_in  = sqx_ff + sqy_ff;
      f_in  = sfx_ff + sfy_ff;
      for (int k = 1; k <= QB; k++) begin
         trial_in[k] = {1'b0, rem_ff[k-1]} - ({17'b0, den_ff[k-1]} << (QB - k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
         v6_ff <= v5_ff; v7_ff <= v6_ff; v8_ff <= v7_ff; v9_ff <= v8_ff;
         vd_ff[0] <= v9_ff;
         for (int k = 1; k <= QB; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // offsets
         dx_ff <= $signed({1'b0, req_pixel_x}) - $signed({1'b0, req_center_x});
         dy_ff <= $signed({1'b0, req_row_y}) - $signed({1'b0, req_center_y});
         c_ff  <= req_cos_angle;
         s_ff  <= req_sin_angle;
         // rotation products
         pxc_ff <= dx_ff * c_ff;
         pys_ff <= dy_ff * s_ff;
         pxs_ff <= dx_ff * s_ff;
         pyc_ff <= dy_ff * c_ff;
         // magnitudes
         mx_ff <= mx_in;
         my_ff <= my_in;
         ax_ff <= aa_ff ? mx_in + ebmf_pkg::AA_ONE : mx_in;
         ay_ff <= aa_ff ? my_in + ebmf_pkg::AA_ONE : my_in;
         // scale products split in halves
         mxh_ff <= mx_ff * xs_ff[31:16];
         mxl_ff <= mx_ff * xs_ff[15:0];
         myh_ff <= my_ff * ys_ff[31:16];
         myl_ff <= my_ff * ys_ff[15:0];
         axh_ff <= ax_ff * fxs_ff[31:16];
         axl_ff <= ax_ff * fxs_ff[15:0];
         ayh_ff <= ay_ff * fys_ff[31:16];
         ayl_ff <= ay_ff * fys_ff[15:0];
         // terms
         tx_ff <= tx_in[17:0];
         ty_ff <= ty_in[17:0];
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         // squares
         sqx_ff <= 36'(tx_ff * tx_ff);
         sqy_ff <= 36'(ty_ff * ty_ff);
         sfx_ff <= fx_ff * fx_ff;
         sfy_ff <= fy_ff * fy_ff;
         // norms
         n_ff <= n_in;
         f_ff <= f_in;
         // classify
         den8_ff <= f_ff - {10'b0, n_ff};
         fm_ff   <= f_ff - ebmf_pkg::NORM_ONE;
         nh_ff   <= n_ff[32:17];
         priority if ({10'b0, n_ff} > ebmf_pkg::NORM_ONE) begin
            fix8_ff <= 1'b1;
            fv8_ff  <= ebmf_pkg::FULL_OUT;
         end else if (f_ff < ebmf_pkg::NORM_ONE) begin
            fix8_ff <= 1'b1;
            fv8_ff  <= 16'd0;
         end else if (f_ff == {10'b0, n_ff}) begin
            fix8_ff <= 1'b1;
            fv8_ff  <= ebmf_pkg::FULL_OUT;
         end else begin
            fix8_ff <= 1'b0;
            fv8_ff  <= 16'd0;
         end
         // numerator
         num_ff  <= nh_ff * fm_ff;
         den9_ff <= den8_ff;
         fix9_ff <= fix8_ff;
         fv9_ff  <= fv8_ff;
         // quotient overflow check
         den_ff[0] <= den9_ff;
         rem_ff[0] <= num_ff;
         priority if (fix9_ff) begin
            dv_ff[0] <= 1'b0;
            q_ff[0]  <= fv9_ff;
         end else if ({1'b0, num_ff} >= ({17'b0, den9_ff} << QB)) begin
            dv_ff[0] <= 1'b0;
            q_ff[0]  <= ebmf_pkg::FULL_OUT;
         end else begin
            dv_ff[0] <= 1'b1;
            q_ff[0]  <= 16'd0;
         end
         // one quotient bit per stage
         for (int k = 1; k <= QB; k++) begin
            den_ff[k] <= den_ff[k-1];
            dv_ff[k]  <= dv_ff[k-1];
            if (dv_ff[k-1] && !trial_in[k][62]) begin
               rem_ff[k] <= trial_in[k][61:0];
               q_ff[k]   <= q_ff[k-1] | (16'd1 << (QB - k));
            end else begin
               rem_ff[k] <= rem_ff[k-1];
               q_ff[k]   <= q_ff[k-1];
            end
         end
      end
   end

   assign rsp_valid      = vd_ff[QB];
   assign rsp_fade_value = q_ff[QB];
endmodule

// ===== hdl/ebmf_checker.sv =====
// port-level checks for the brush mask block, bound to the top level
// depends on assert_macros.svh and ellipse_brush_mask_fade_top
`include "assert_macros.svh"
module ebmf_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_fade_value
);
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fade_value))
   `AST_NOW(a_rsp_range, clock, reset, rsp_valid, rsp_fade_value <= 16'h8000)
   `AST_NOW(a_backpressure, clock, reset, 1'b1, req_stall == (rsp_valid && rsp_stall))
   `AST_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
endmodule

bind ellipse_brush_mask_fade_top ebmf_port_checks u_ebmf_port_checks (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_fade_value(rsp_fade_value)
);
